/* design/fpa_pkg.sv */
// Shared constants and types for the fit-policy partition allocator.
`default_nettype none
package fpa_pkg;

  // Table geometry
  localparam int unsigned MaxParts = 16;
  localparam int unsigned SizeBits = 16;
  localparam int unsigned IdxW     = $clog2(MaxParts);
  localparam int unsigned CntW     = $clog2(MaxParts + 1);
  localparam int unsigned IntW     = 20;
  localparam int unsigned ExtW     = 32;

  typedef logic [SizeBits-1:0] size_t;

  typedef enum logic [1:0] {
    CmdAdd     = 2'd0,
    CmdAlloc   = 2'd1,
    CmdRestart = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PolFirst = 2'd0,
    PolBest  = 2'd1,
    PolWorst = 2'd2
  } policy_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatUnalloc = 2'd1,
    StatFull    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StSweep,
    StUpdate,
    StResp
  } state_e;

endpackage : fpa_pkg
`default_nettype wire

/* design/fit_policy_partition_allocator.sv */
// Top level: partition table with first/best/worst fit allocation sequencer.
// An allocate item scans one entry per cycle with one shared compare unit; first fit stops early.
// A restart sweeps the table; add and ignored commands go straight to the result.
// The result is registered as ready returns; a stalled result holds the sequencer.
// Reset (rst_ni, asynchronous, active low) empties the table, clears both totals and the policy.
`default_nettype none
module fit_policy_partition_allocator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_policy_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        command_i,
  input  wire logic [15:0]                       request_size_i,
  // result items
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             status_o,
  output logic [4:0]                             part_num_o,
  output logic [19:0]                            internal_fragmentation_o,
  output logic [31:0]                            external_fragmentation_o
);

  // Table storage
  fpa_pkg::size_t size_mem [fpa_pkg::MaxParts];
  fpa_pkg::size_t free_mem [fpa_pkg::MaxParts];

  fpa_pkg::state_e state_q, state_d;

  logic [1:0]                 policy_q;
  fpa_pkg::size_t             req_q;
  logic [fpa_pkg::CntW-1:0]   count_q;
  logic [fpa_pkg::IdxW-1:0]   idx_q;
  logic                       found_q;
  logic [fpa_pkg::IdxW-1:0]   sel_q;
  fpa_pkg::size_t             best_free_q;
  fpa_pkg::size_t             best_size_q;
  logic [fpa_pkg::IntW-1:0]   int_q;
  logic [fpa_pkg::ExtW-1:0]   ext_q;
  logic [1:0]                 res_status_q;
  logic [fpa_pkg::CntW-1:0]   res_num_q;

  logic                       out_valid_q;
  logic [1:0]                 out_status_q;
  logic [fpa_pkg::CntW-1:0]   out_num_q;
  logic [fpa_pkg::IntW-1:0]   out_int_q;
  logic [fpa_pkg::ExtW-1:0]   out_ext_q;

  logic                       in_acc;
  logic                       out_free;
  fpa_pkg::size_t             req_in;
  fpa_pkg::size_t             cur_free;
  fpa_pkg::size_t             cur_size;
  logic                       fits;
  logic                       take;
  logic                       first_pol;
  logic                       last_idx;
  logic                       table_full;
  fpa_pkg::size_t             new_free;
  logic [fpa_pkg::ExtW:0]     ext_sum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == fpa_pkg::StIdle);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign req_in      = request_size_i[fpa_pkg::SizeBits-1:0];

  // Shared compare unit on the scanned entry
  assign cur_free  = free_mem[idx_q];
  assign cur_size  = size_mem[idx_q];
  assign fits      = (cur_free >= req_q);
  assign first_pol = (policy_q != fpa_pkg::PolBest) && (policy_q != fpa_pkg::PolWorst);
  assign last_idx  = (fpa_pkg::CntW'(idx_q) + fpa_pkg::CntW'(1)) == count_q;
  assign table_full = (count_q == fpa_pkg::CntW'(fpa_pkg::MaxParts));

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (policy_q == fpa_pkg::PolBest) begin
        take = (cur_free <= best_free_q);
      end else if (policy_q == fpa_pkg::PolWorst) begin
        take = (cur_free >= best_free_q);
      end
    end
  end

  assign new_free = best_free_q - req_q;
  assign ext_sum  = {1'b0, ext_q} + (fpa_pkg::ExtW+1)'(req_q);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpa_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpa_pkg::StIdle: begin
        if (in_acc) begin
          if (command_i == fpa_pkg::CmdAlloc) begin
            state_d = (count_q == '0) ? fpa_pkg::StUpdate : fpa_pkg::StScan;
          end else if (command_i == fpa_pkg::CmdRestart) begin
            state_d = (count_q == '0) ? fpa_pkg::StResp : fpa_pkg::StSweep;
          end else begin
            state_d = fpa_pkg::StResp;
          end
        end
      end
      fpa_pkg::StScan: begin
        if (last_idx || (first_pol && fits)) begin
          state_d = fpa_pkg::StUpdate;
        end
      end
      fpa_pkg::StSweep: begin
        if (last_idx) begin
          state_d = fpa_pkg::StResp;
        end
      end
      fpa_pkg::StUpdate: begin
        state_d = fpa_pkg::StResp;
      end
      fpa_pkg::StResp: begin
        if (out_free) begin
          state_d = fpa_pkg::StIdle;
        end
      end
      default: state_d = fpa_pkg::StIdle;
    endcase
  end

  // Table writes: add, grant and restart sweep
  always_ff @(posedge clk_i) begin
    if (state_q == fpa_pkg::StIdle && in_acc && command_i == fpa_pkg::CmdAdd && !table_full) begin
      size_mem[count_q[fpa_pkg::IdxW-1:0]] <= req_in;
      free_mem[count_q[fpa_pkg::IdxW-1:0]] <= req_in;
    end else if (state_q == fpa_pkg::StUpdate && found_q) begin
      free_mem[sel_q] <= new_free;
    end else if (state_q == fpa_pkg::StSweep) begin
      free_mem[idx_q] <= cur_size;
    end
  end

  // Control and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= fpa_pkg::PolFirst;
      count_q      <= '0;
      int_q        <= '0;
      ext_q        <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      res_status_q <= fpa_pkg::StatOk;
      res_num_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        policy_q <= cfg_policy_i;
      end
      unique case (state_q)
        fpa_pkg::StIdle: begin
          if (in_acc) begin
            idx_q        <= '0;
            found_q      <= 1'b0;
            res_status_q <= fpa_pkg::StatOk;
            res_num_q    <= '0;
            if (command_i == fpa_pkg::CmdAdd) begin
              if (table_full) begin
                res_status_q <= fpa_pkg::StatFull;
              end else begin
                count_q   <= count_q + fpa_pkg::CntW'(1);
                res_num_q <= count_q + fpa_pkg::CntW'(1);
              end
            end else if (command_i == fpa_pkg::CmdRestart) begin
              int_q <= '0;
              ext_q <= '0;
            end
          end
        end
        fpa_pkg::StScan: begin
          if (take) begin
            found_q <= 1'b1;
          end
          idx_q <= idx_q + fpa_pkg::IdxW'(1);
        end
        fpa_pkg::StSweep: begin
          idx_q <= idx_q + fpa_pkg::IdxW'(1);
        end
        fpa_pkg::StUpdate: begin
          if (found_q) begin
            res_num_q <= fpa_pkg::CntW'(sel_q) + fpa_pkg::CntW'(1);
            // an untouched partition joins the total; a touched one just shrinks
            if (req_q != '0) begin
              if (best_free_q == best_size_q) begin
                int_q <= int_q + fpa_pkg::IntW'(new_free);
              end else begin
                int_q <= int_q - fpa_pkg::IntW'(req_q);
              end
            end
          end else begin
            res_status_q <= fpa_pkg::StatUnalloc;
            ext_q <= ext_sum[fpa_pkg::ExtW] ? '1 : ext_sum[fpa_pkg::ExtW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Scan payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_in;
    end
    if (state_q == fpa_pkg::StScan && take) begin
      sel_q       <= idx_q;
      best_free_q <= cur_free;
      best_size_q <= cur_size;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == fpa_pkg::StResp && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fpa_pkg::StResp && out_free) begin
      out_status_q <= res_status_q;
      out_num_q    <= res_num_q;
      out_int_q    <= int_q;
      out_ext_q    <= ext_q;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign status_o                 = out_status_q;
  assign part_num_o               = out_num_q;
  assign internal_fragmentation_o = out_int_q;
  assign external_fragmentation_o = out_ext_q;

endmodule : fit_policy_partition_allocator
`default_nettype wire

/* design/fpa_checker.sv */
// Port-level checker for the partition allocator, bound to the top level.
`default_nettype none
module fpa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [4:0]  part_num_o,
  input wire logic [19:0] internal_fragmentation_o,
  input wire logic [31:0] external_fragmentation_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(part_num_o) && $stable(internal_fragmentation_o)
      && $stable(external_fragmentation_o))
    else $error("stalled result changed");

  // an accepted item makes the block busy: input ready is low in the cycle after the accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready straight after accept");

  // failed or refused items carry no partition number
  a_no_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fpa_pkg::StatUnalloc || status_o == fpa_pkg::StatFull)
      |-> part_num_o == '0)
    else $error("partition number on failed item");

  // number within the table and status a known code
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> part_num_o <= 5'(fpa_pkg::MaxParts)
      && (status_o == fpa_pkg::StatOk || status_o == fpa_pkg::StatUnalloc
        || status_o == fpa_pkg::StatFull))
    else $error("result out of range");

  // internal total never exceeds a full table of fully free partitions
  a_int_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> internal_fragmentation_o
      <= 20'(fpa_pkg::MaxParts * ((1 << fpa_pkg::SizeBits) - 1)))
    else $error("internal total out of range");

endmodule : fpa_checker

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (.*);
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the fit-policy partition allocator.
`timescale 1ns / 100ps
module testbench;

  // Codes outside the package enums
  localparam logic [1:0] CmdNone  = 2'd3;  // ignored command
  localparam logic [1:0] PolAlias = 2'd3;  // unused policy, acts as first fit

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems = 190;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned NumRows = 24;
  localparam int unsigned ReportLimit = 10;

  typedef enum logic [1:0] {
    ModeSteady,
    ModeSendGaps,
    ModeRecvStall,
    ModeBoth
  } idle_mode_e;

  typedef enum logic {
    RowItem,
    RowPolicy
  } row_kind_e;

  // One row of the directed table; a policy row carries the policy in size
  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       cmd;
    fpa_pkg::size_t   size;
    logic [4:0]       reps;
    logic             rand_size;
    logic             typed;
    fpa_pkg::status_e status;
    logic [4:0]       number;
  } dir_row_t;

  typedef struct packed {
    fpa_pkg::status_e status;
    logic [4:0]       number;
    logic [19:0]      int_frag;
    logic [31:0]      ext_frag;
  } grant_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_policy;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [15:0] request_size;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [4:0]  part_num;
  logic [19:0] internal_fragmentation;
  logic [31:0] external_fragmentation;

  // Shadow of the allocator state
  fpa_pkg::size_t part_size [fpa_pkg::MaxParts];
  fpa_pkg::size_t free_sp [fpa_pkg::MaxParts];
  int unsigned    n_parts;
  logic [31:0]    ext_total;
  logic [1:0]     cur_policy;

  grant_t      grant_queue[$];
  int unsigned error_count;
  int unsigned cycle_count;
  idle_mode_e  idle_mode;
  bit          hold_request;
  int unsigned hold_left;

  dir_row_t directed_rows [NumRows] = '{
    // empty table: every request fails
    '{RowItem, fpa_pkg::CmdAlloc, 16'hFFFF, 5'd1, 1'b0, 1'b1, fpa_pkg::StatUnalloc, 5'd0},
    '{RowItem, fpa_pkg::CmdAlloc, 16'h0000, 5'd1, 1'b0, 1'b1, fpa_pkg::StatUnalloc, 5'd0},
    '{RowItem, CmdNone, 16'h1234, 5'd1, 1'b0, 1'b1, fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdRestart, 16'hABCD, 5'd1, 1'b0, 1'b1, fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdAdd, 16'hFFFF, 5'd1, 1'b0, 1'b1, fpa_pkg::StatOk, 5'd1},
    '{RowItem, fpa_pkg::CmdAdd, 16'h0000, 5'd1, 1'b0, 1'b1, fpa_pkg::StatOk, 5'd2},
    '{RowItem, fpa_pkg::CmdAdd, 16'd100, 5'd1, 1'b0, 1'b1, fpa_pkg::StatOk, 5'd3},
    '{RowItem, fpa_pkg::CmdAdd, 16'd50, 5'd1, 1'b0, 1'b1, fpa_pkg::StatOk, 5'd4},
    '{RowItem, fpa_pkg::CmdAlloc, 16'h0000, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdAlloc, 16'd40, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowPolicy, fpa_pkg::CmdAdd, 16'(fpa_pkg::PolBest), 5'd1, 1'b0, 1'b0,
      fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdAlloc, 16'd30, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdAlloc, 16'h0000, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowPolicy, fpa_pkg::CmdAdd, 16'(fpa_pkg::PolWorst), 5'd1, 1'b0, 1'b0,
      fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdAlloc, 16'd60, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdAlloc, 16'hFFFF, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowPolicy, fpa_pkg::CmdAdd, 16'(PolAlias), 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdAlloc, 16'd10, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    // fill the rest of the table with random sizes
    '{RowItem, fpa_pkg::CmdAdd, 16'h0000, 5'd12, 1'b1, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdAdd, 16'h5555, 5'd1, 1'b0, 1'b1, fpa_pkg::StatFull, 5'd0},
    '{RowItem, fpa_pkg::CmdAlloc, 16'hFFFF, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowItem, fpa_pkg::CmdRestart, 16'h0000, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowItem, CmdNone, 16'hFFFF, 5'd1, 1'b0, 1'b0, fpa_pkg::StatOk, 5'd0},
    '{RowPolicy, fpa_pkg::CmdAdd, 16'(fpa_pkg::PolFirst), 5'd1, 1'b0, 1'b0,
      fpa_pkg::StatOk, 5'd0}
  };

  fit_policy_partition_allocator dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_valid_i              (cfg_valid),
    .cfg_ready_o              (cfg_ready),
    .cfg_policy_i             (cfg_policy),
    .in_valid_i               (in_valid),
    .in_ready_o               (in_ready),
    .command_i                (command),
    .request_size_i           (request_size),
    .out_valid_o              (out_valid),
    .out_ready_i              (out_ready),
    .status_o                 (status),
    .part_num_o               (part_num),
    .internal_fragmentation_o (internal_fragmentation),
    .external_fragmentation_o (external_fragmentation)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Chosen partition under the current policy, -1 if nothing fits
  function automatic int pick_slot(input fpa_pkg::size_t req);
    int sel;
    sel = -1;
    for (int i = 0; i < int'(n_parts); i++) begin
      if (free_sp[i] >= req) begin
        if (cur_policy == fpa_pkg::PolBest) begin
          if (sel < 0 || free_sp[i] <= free_sp[sel]) sel = i;
        end else if (cur_policy == fpa_pkg::PolWorst) begin
          if (sel < 0 || free_sp[i] >= free_sp[sel]) sel = i;
        end else begin
          return i;
        end
      end
    end
    return sel;
  endfunction

  // Applies one command to the shadow table and returns the grant it yields
  function automatic grant_t compute_grant(input logic [1:0] cmd, input fpa_pkg::size_t req);
    grant_t      g;
    int          sel;
    logic [32:0] ext_sum;
    logic [24:0] acc;
    g.status = fpa_pkg::StatOk;
    g.number = '0;
    case (cmd)
      fpa_pkg::CmdAdd: begin
        if (n_parts < fpa_pkg::MaxParts) begin
          part_size[n_parts] = req;
          free_sp[n_parts] = req;
          n_parts++;
          g.number = 5'(n_parts);
        end else begin
          g.status = fpa_pkg::StatFull;
        end
      end
      fpa_pkg::CmdAlloc: begin
        sel = pick_slot(req);
        if (sel >= 0) begin
          free_sp[sel] = free_sp[sel] - req;
          g.number = 5'(sel + 1);
        end else begin
          ext_sum = {1'b0, ext_total} + 33'(req);
          ext_total = ext_sum[32] ? 32'hFFFF_FFFF : ext_sum[31:0];
          g.status = fpa_pkg::StatUnalloc;
        end
      end
      fpa_pkg::CmdRestart: begin
        for (int i = 0; i < int'(n_parts); i++) free_sp[i] = part_size[i];
        ext_total = '0;
      end
      default: ;
    endcase
    // touched partitions only
    acc = '0;
    for (int i = 0; i < int'(n_parts); i++) begin
      if (part_size[i] != free_sp[i]) acc = acc + 25'(free_sp[i]);
    end
    g.int_frag = (acc > 25'hFFFFF) ? 20'hFFFFF : acc[19:0];
    g.ext_frag = ext_total;
    return g;
  endfunction

  // Partition sizes spread over all magnitudes
  function automatic fpa_pkg::size_t random_part_size();
    return fpa_pkg::size_t'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 15));
  endfunction

  // Offer one item, with sender gaps as the idle mode asks
  task automatic send_item(input logic [1:0] cmd, input fpa_pkg::size_t req,
                           input logic typed, input fpa_pkg::status_e st,
                           input logic [4:0] num);
    grant_t g;
    int unsigned gap_pct;
    gap_pct = (idle_mode == ModeSendGaps) ? 82 : (idle_mode == ModeBoth) ? 14 : 0;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    command <= cmd;
    request_size <= req;
    do @(posedge clk_i); while (!in_ready);
    g = compute_grant(cmd, req);
    if (typed) begin
      g.status = st;
      g.number = num;
    end
    grant_queue = {grant_queue, g};
  endtask

  // Lower valid right after the last accepted item
  task automatic drop_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // Policy write, only once every grant has come back
  task automatic write_policy(input logic [1:0] pol);
    drop_input();
    while (grant_queue.size() != 0) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_policy <= pol;
    do @(posedge clk_i); while (!cfg_ready);
    cur_policy = pol;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stalls by idle mode, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (idle_mode == ModeRecvStall) begin
      out_ready <= ($urandom_range(0, 99) >= 82);
    end else if (idle_mode == ModeBoth) begin
      out_ready <= ($urandom_range(0, 99) >= 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && out_valid && out_ready) begin
      if (grant_queue.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("%0t: result with nothing outstanding: status %0d number %0d",
                   $realtime, status, part_num);
      end else begin
        g = grant_queue.pop_front();
        if (status !== g.status || part_num !== g.number ||
            internal_fragmentation !== g.int_frag ||
            external_fragmentation !== g.ext_frag) begin
          error_count++;
          if (error_count <= ReportLimit)
            $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d", $realtime,
                     g.status, g.number, g.int_frag, g.ext_frag, status, part_num,
                     internal_fragmentation, external_fragmentation);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Stimulus
  initial begin
    dir_row_t       row;
    int unsigned    roll;
    int unsigned    slot;
    logic [1:0]     cmd;
    fpa_pkg::size_t req;
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_policy = fpa_pkg::PolFirst;
    in_valid = 1'b0;
    command = fpa_pkg::CmdAdd;
    request_size = '0;
    out_ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    idle_mode = ModeSteady;
    hold_request = 1'b0;
    hold_left = 0;
    n_parts = 0;
    ext_total = '0;
    cur_policy = fpa_pkg::PolFirst;
    foreach (part_size[i]) begin
      part_size[i] = '0;
      free_sp[i] = '0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == RowPolicy) begin
        write_policy(row.size[1:0]);
      end else begin
        for (int k = 0; k < int'(row.reps); k++)
          send_item(row.cmd, row.rand_size ? random_part_size() : row.size,
                    row.typed, row.status, row.number);
      end
    end

    // Random phases: each idle mode under different policies
    for (int ph = 0; ph < int'(NumPhases); ph++) begin
      write_policy(2'((ph + ph / 4) % 4));
      idle_mode = idle_mode_e'(ph % 4);
      if (ph == 0) hold_request = 1'b1;
      for (int n = 0; n < int'(PhaseItems); n++) begin
        roll = $urandom_range(0, 99);
        req = fpa_pkg::size_t'($urandom_range(0, 16'hFFFF));
        if (roll < 3) begin
          cmd = fpa_pkg::CmdRestart;
        end else if (roll < 5) begin
          cmd = CmdNone;
        end else if (roll < 8) begin
          cmd = fpa_pkg::CmdAdd;
          req = random_part_size();
        end else begin
          // requests sized against one partition's free space, or left random
          cmd = fpa_pkg::CmdAlloc;
          if (n_parts != 0) begin
            slot = $urandom_range(0, n_parts - 1);
            roll = $urandom_range(0, 9);
            if (roll < 5) req = fpa_pkg::size_t'($urandom_range(0, free_sp[slot]));
            else if (roll < 7) req = free_sp[slot];
            else if (roll < 8) req = (free_sp[slot] == 16'hFFFF) ? 16'hFFFF
                                                                 : free_sp[slot] + 1'b1;
            else if (roll < 9) req = '0;
          end
        end
        send_item(cmd, req, 1'b0, fpa_pkg::StatOk, 5'd0);
      end
    end

    // Drain and settle
    drop_input();
    while (grant_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
design/fpa_pkg.sv
design/fit_policy_partition_allocator.sv
design/fpa_checker.sv
test/testbench.sv
